/* rtl/trme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_pkg: shared types and codes of the toy register machine execute block
// Instruction kinds, operand form codes and the structs that travel between
// the execute logic and the register file / data memory.
// ----------------------------------------------------------------------------
package trme_pkg;

  // Fixed widths of the instruction and result words
  localparam int KindW   = 3;
  localparam int FormW   = 3;
  localparam int RegSelW = 3;
  localparam int AddrW   = 6;
  localparam int DataW   = 32;
  localparam int TargetW = 9;
  localparam int LineW   = 8;

  // Instruction kinds; code 7 is a no-operation
  typedef enum logic [KindW-1:0] {
    KIND_MOV = 3'd0,
    KIND_ADD = 3'd1,
    KIND_SUB = 3'd2,
    KIND_PRN = 3'd3,
    KIND_JMP = 3'd4,
    KIND_JPN = 3'd5,
    KIND_HLT = 3'd6
  } kind_e;

  // Operand forms of MOV, ADD and SUB
  localparam logic [FormW-1:0] FORM_REG_REG   = 3'd0;
  localparam logic [FormW-1:0] FORM_REG_CONST = 3'd1;
  localparam logic [FormW-1:0] FORM_REG_MEM   = 3'd2;
  localparam logic [FormW-1:0] FORM_MEM_REG   = 3'd3;
  localparam logic [FormW-1:0] FORM_MEM_CONST = 3'd4;

  // Operand forms of PRN and JMP
  localparam logic [FormW-1:0] FORM_REG   = 3'd0;
  localparam logic [FormW-1:0] FORM_CONST = 3'd1;
  localparam logic [FormW-1:0] FORM_MEM   = 3'd2;

  // Read request issued when a word is taken in
  typedef struct packed {
    logic               en;
    logic [RegSelW-1:0] reg_a;
    logic [RegSelW-1:0] reg_b;
    logic [AddrW-1:0]   mem_addr;
  } rd_req_t;

  // Registered read data, valid the cycle after the request
  typedef struct packed {
    logic [DataW-1:0] reg_a_val;
    logic [DataW-1:0] reg_b_val;
    logic [DataW-1:0] mem_val;
  } rd_rsp_t;

  // Single write port shared by register file and data memory
  typedef struct packed {
    logic               reg_we;
    logic [RegSelW-1:0] reg_sel;
    logic               mem_we;
    logic [AddrW-1:0]   mem_addr;
    logic [DataW-1:0]   data;
  } wr_t;

endpackage

/* rtl/toy_register_machine_execute_top.sv */
`timescale 1ns / 1ps
// An accepted input word goes to the input register, its result to the result
// register. Throughput: one word per cycle unless output stall holds a result;
// operand reads are registered, with the write of the executing word forwarded to the next.
// Input stall rises only while a result word is held by output stall.
// Reset (asynchronous, active low) zeroes the line index, halt flag and
// registers at once; data memory words read as zero until written.
// ----------------------------------------------------------------------------
// toy_register_machine_execute_top: execute stage of a five-register toy machine
// Runs one decoded instruction per word against registers and data memory and
// returns the next line to fetch, an optional print event and the halt flag.
// ----------------------------------------------------------------------------
module toy_register_machine_execute_top
  import trme_pkg::*;
#(
  parameter int MEM_WORDS     = 64,
  parameter int NUM_REGS      = 5,
  parameter int PROGRAM_LINES = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [KindW-1:0]          kind_i,
  input  logic [FormW-1:0]          operand_form_i,
  input  logic [RegSelW-1:0]        reg_a_i,
  input  logic [RegSelW-1:0]        reg_b_i,
  input  logic [AddrW-1:0]          mem_address_i,
  input  logic signed [DataW-1:0]   immediate_i,
  input  logic [TargetW-1:0]        target_line_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [LineW-1:0]          next_line_o,
  output logic                      print_valid_o,
  output logic signed [DataW-1:0]   print_value_o,
  output logic                      print_unsigned_o,
  output logic                      halted_o
);

  localparam int LW = $clog2(PROGRAM_LINES);

  // Handshake
  logic    adv, accept, fire;
  rd_req_t rd_req;
  rd_rsp_t rd_rsp;
  wr_t     wr;

  // Input register
  logic               s1_vld_q;
  kind_e              s1_kind_q;
  logic [FormW-1:0]   s1_form_q;
  logic [RegSelW-1:0] s1_ra_q, s1_rb_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [DataW-1:0]   s1_imm_q;
  logic [LW-1:0]      s1_jdest_q;

  // Architectural state
  logic [LW-1:0] line_q, line_d;
  logic          halt_q, halt_d;

  // Result register
  logic             out_vld_q;
  logic [LineW-1:0] next_line_q;
  logic             pvalid_q, punsigned_q, halted_q;
  logic [DataW-1:0] pvalue_q;
  logic             pvalid_d, punsigned_d;
  logic [DataW-1:0] pvalue_d;

  logic [TargetW-1:0] jt;
  logic [LW-1:0]      jdest;
  logic [LW-1:0]      line_inc;
  logic [DataW-1:0]   opa, opb, alu;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = s1_vld_q && adv;

  // Reduce the one-based target modulo the program length, then step back one
  always_comb begin
    jt = target_line_i;
    for (int k = 4; k >= 0; k--) begin
      if (32'(jt) >= (PROGRAM_LINES << k)) begin
        jt = jt - TargetW'(PROGRAM_LINES << k);
      end
    end
    jdest = (jt == '0) ? LW'(PROGRAM_LINES - 1) : LW'(jt - TargetW'(1));
  end

  // Operand read request
  always_comb begin
    rd_req.en       = accept;
    rd_req.reg_a    = reg_a_i;
    rd_req.reg_b    = reg_b_i;
    rd_req.mem_addr = mem_address_i;
  end

  trme_store #(
    .NUM_REGS  (NUM_REGS),
    .MEM_WORDS (MEM_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_req_i (rd_req),
    .wr_i     (wr),
    .rd_rsp_o (rd_rsp)
  );

  // Capture the instruction word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= kind_e'(kind_i);
      s1_form_q  <= operand_form_i;
      s1_ra_q    <= reg_a_i;
      s1_rb_q    <= reg_b_i;
      s1_addr_q  <= mem_address_i;
      s1_imm_q   <= immediate_i;
      s1_jdest_q <= jdest;
    end
  end

  // Execute
  always_comb begin
    line_inc = (line_q == LW'(PROGRAM_LINES - 1)) ? '0 : line_q + LW'(1);
    opa      = rd_rsp.reg_a_val;
    line_d   = line_inc;
    halt_d   = halt_q;
    pvalid_d = 1'b0;
    pvalue_d = '0;
    punsigned_d = 1'b0;
    wr.reg_we   = 1'b0;
    wr.reg_sel  = s1_ra_q;
    wr.mem_we   = 1'b0;
    wr.mem_addr = s1_addr_q;
    wr.data     = '0;

    // select the second ALU operand
    case (s1_form_q)
      FORM_REG_REG:   opb = rd_rsp.reg_b_val;
      FORM_REG_CONST: opb = s1_imm_q;
      default:        opb = rd_rsp.mem_val;
    endcase
    alu = (s1_kind_q == KIND_ADD) ? opa + opb : opa - opb;

    if (halt_q) begin
      line_d = line_q;
    end else begin
      unique case (s1_kind_q)
        KIND_MOV: begin
          case (s1_form_q)
            FORM_REG_REG: begin
              wr.reg_we  = 1'b1;
              wr.reg_sel = s1_rb_q;
              wr.data    = opa;
            end
            FORM_REG_CONST: begin
              wr.reg_we = 1'b1;
              wr.data   = s1_imm_q;
            end
            FORM_REG_MEM: begin
              wr.mem_we = 1'b1;
              wr.data   = opa;
            end
            FORM_MEM_REG: begin
              wr.reg_we = 1'b1;
              wr.data   = rd_rsp.mem_val;
            end
            FORM_MEM_CONST: begin
              wr.mem_we = 1'b1;
              wr.data   = s1_imm_q;
            end
            default: ;
          endcase
        end
        KIND_ADD, KIND_SUB: begin
          case (s1_form_q) inside
            FORM_REG_REG, FORM_REG_CONST, FORM_REG_MEM: begin
              wr.reg_we = 1'b1;
              wr.data   = alu;
            end
            default: ;
          endcase
        end
        KIND_PRN: begin
          case (s1_form_q)
            FORM_REG: begin
              pvalid_d = 1'b1;
              pvalue_d = opa;
            end
            FORM_CONST: begin
              pvalid_d = 1'b1;
              pvalue_d = s1_imm_q;
            end
            FORM_MEM: begin
              pvalid_d    = 1'b1;
              pvalue_d    = rd_rsp.mem_val;
              punsigned_d = 1'b1;
            end
            default: ;
          endcase
        end
        KIND_JMP: begin
          if (s1_form_q != FORM_REG || opa == '0) begin
            line_d = s1_jdest_q;
          end
        end
        KIND_JPN: begin
          if (opa == '0 || opa[DataW-1]) begin
            line_d = s1_jdest_q;
          end
        end
        KIND_HLT: begin
          halt_d = 1'b1;
          line_d = line_q;
        end
        default: ;
      endcase
    end

    // drop writes unless the word really executes this cycle
    wr.reg_we = wr.reg_we && fire;
    wr.mem_we = wr.mem_we && fire;
  end

  // Advance line index and halt flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      halt_q <= 1'b0;
    end else if (fire) begin
      line_q <= line_d;
      halt_q <= halt_d;
    end
  end

  // Result register; hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      next_line_q <= LineW'(line_d);
      pvalid_q    <= pvalid_d;
      pvalue_q    <= pvalue_d;
      punsigned_q <= punsigned_d;
      halted_q    <= halt_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign next_line_o      = next_line_q;
  assign print_valid_o    = pvalid_q;
  assign print_value_o    = pvalue_q;
  assign print_unsigned_o = punsigned_q;
  assign halted_o         = halted_q;

endmodule

/* rtl/trme_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_store: register file and data memory of the toy register machine
// Two register reads and one memory read per request, registered, with
// forwarding of the write issued in the same cycle. Data memory entries carry
// valid bits so that unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module trme_store
  import trme_pkg::*;
#(
  parameter int NUM_REGS  = 5,
  parameter int MEM_WORDS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_req_t rd_req_i,
  input  wr_t     wr_i,
  output rd_rsp_t rd_rsp_o
);

  localparam int RegIdxW  = $clog2(NUM_REGS);
  localparam int RegWideW = (RegIdxW > RegSelW) ? RegIdxW : RegSelW;
  localparam int MemIdxW  = $clog2(MEM_WORDS);
  localparam int MemWideW = (MemIdxW > AddrW) ? MemIdxW : AddrW;

  function automatic logic [RegIdxW-1:0] reg_idx(input logic [RegSelW-1:0] sel);
    logic [RegWideW-1:0] wide;
    wide = RegWideW'(sel);
    return wide[RegIdxW-1:0];
  endfunction

  function automatic logic [MemIdxW-1:0] mem_idx(input logic [AddrW-1:0] addr);
    logic [MemWideW-1:0] wide;
    wide = MemWideW'(addr);
    return wide[MemIdxW-1:0];
  endfunction

  logic [DataW-1:0] regs_q [NUM_REGS];
  logic [DataW-1:0] mem_q  [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_vld_q;

  logic [DataW-1:0] reg_a_q, reg_b_q, mem_raw_q, mem_fwd_q;
  logic             mem_zero_q, mem_hit_q;

  logic reg_wr_ok, mem_wr_ok;
  logic ra_ok, rb_ok, rm_ok;
  logic hit_a, hit_b, hit_m;

  // Range checks and forwarding matches
  always_comb begin
    reg_wr_ok = wr_i.reg_we && (32'(wr_i.reg_sel) < 32'(NUM_REGS));
    mem_wr_ok = wr_i.mem_we && (32'(wr_i.mem_addr) < 32'(MEM_WORDS));
    ra_ok     = 32'(rd_req_i.reg_a) < 32'(NUM_REGS);
    rb_ok     = 32'(rd_req_i.reg_b) < 32'(NUM_REGS);
    rm_ok     = 32'(rd_req_i.mem_addr) < 32'(MEM_WORDS);
    hit_a     = reg_wr_ok && (wr_i.reg_sel == rd_req_i.reg_a);
    hit_b     = reg_wr_ok && (wr_i.reg_sel == rd_req_i.reg_b);
    hit_m     = mem_wr_ok && (wr_i.mem_addr == rd_req_i.mem_addr);
  end

  // Register file: write and registered reads with forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (reg_wr_ok) begin
      regs_q[reg_idx(wr_i.reg_sel)] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      reg_a_q <= !ra_ok ? '0 : (hit_a ? wr_i.data : regs_q[reg_idx(rd_req_i.reg_a)]);
      reg_b_q <= !rb_ok ? '0 : (hit_b ? wr_i.data : regs_q[reg_idx(rd_req_i.reg_b)]);
    end
  end

  // Data memory array: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_wr_ok) begin
      mem_q[mem_idx(wr_i.mem_addr)] <= wr_i.data;
    end
    if (rd_req_i.en) begin
      mem_raw_q <= mem_q[mem_idx(rd_req_i.mem_addr)];
      mem_fwd_q <= wr_i.data;
    end
  end

  // Valid bits and read select of the data memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q  <= '0;
      mem_zero_q <= 1'b1;
      mem_hit_q  <= 1'b0;
    end else begin
      if (mem_wr_ok) begin
        mem_vld_q[mem_idx(wr_i.mem_addr)] <= 1'b1;
      end
      if (rd_req_i.en) begin
        mem_zero_q <= !rm_ok || (!hit_m && !mem_vld_q[mem_idx(rd_req_i.mem_addr)]);
        mem_hit_q  <= hit_m;
      end
    end
  end

  assign rd_rsp_o.reg_a_val = reg_a_q;
  assign rd_rsp_o.reg_b_val = reg_b_q;
  assign rd_rsp_o.mem_val   = mem_zero_q ? '0 : (mem_hit_q ? mem_fwd_q : mem_raw_q);

endmodule

/* rtl/trme_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_checker: port-level checks of the toy register machine execute block
// Watches the result channel for held words, input stalls without a held result,
// print field cleanliness and the frozen line after a halt.
// ----------------------------------------------------------------------------
module trme_checker
  import trme_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [LineW-1:0]        next_line_o,
  input logic                    print_valid_o,
  input logic signed [DataW-1:0] print_value_o,
  input logic                    print_unsigned_o,
  input logic                    halted_o
);

  logic             out_acc;
  logic             seen_halt_q;
  logic [LineW-1:0] last_line_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // Track the last delivered line and whether a halt was delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
      last_line_q <= '0;
    end else if (out_acc) begin
      seen_halt_q <= seen_halt_q || halted_o;
      last_line_q <= next_line_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_line_o)
      && $stable(print_value_o) && $stable(halted_o))
    else $error("result word changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result word");

  a_print_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !print_valid_o |-> print_value_o == '0 && !print_unsigned_o)
    else $error("print fields set without a print event");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_halt_q |-> halted_o && !print_valid_o)
    else $error("word after halt is not frozen");

  a_halt_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> next_line_o == last_line_q)
    else $error("line moved while halted");

endmodule

bind toy_register_machine_execute_top trme_checker u_trme_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .next_line_o      (next_line_o),
  .print_valid_o    (print_valid_o),
  .print_value_o    (print_value_o),
  .print_unsigned_o (print_unsigned_o),
  .halted_o         (halted_o)
);

/* tb/sv/trme_exec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_exec_checker: result predictor and scoreboard of the execute block
// Watches both channels of the block. Every accepted instruction word runs
// through a local copy of the machine (line index, registers, data memory,
// halt flag). The expected result word goes into a queue, and each result
// word that leaves the block is compared field by field with the oldest
// entry. The checker reports the failure count and the number of words still
// in flight to the testbench top.
// ----------------------------------------------------------------------------
module trme_exec_checker
  import trme_pkg::*;
#(
  parameter int MEM_WORDS = 64,
  parameter int NUM_REGS  = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // instruction channel
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [KindW-1:0]     kind_i,
  input  logic [FormW-1:0]     operand_form_i,
  input  logic [RegSelW-1:0]   reg_a_i,
  input  logic [RegSelW-1:0]   reg_b_i,
  input  logic [AddrW-1:0]     mem_address_i,
  input  logic [DataW-1:0]     immediate_i,
  input  logic [TargetW-1:0]   target_line_i,
  // result channel
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [LineW-1:0]     next_line_i,
  input  logic                 print_valid_i,
  input  logic [DataW-1:0]     print_value_i,
  input  logic                 print_unsigned_i,
  input  logic                 halted_i,
  // status
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic [LineW-1:0] next_line;
    logic             print_valid;
    logic [DataW-1:0] print_value;
    logic             print_unsigned;
    logic             halted;
  } exec_result_t;

  // Machine state mirrored by the predictor
  logic [LineW-1:0] line_q;
  logic [DataW-1:0] regs_q [NUM_REGS];
  logic [DataW-1:0] mem_q [MEM_WORDS];
  logic             halt_q;

  exec_result_t exec_results_q [$];
  exec_result_t want;
  int           words_seen;

  function automatic logic [DataW-1:0] read_reg(logic [RegSelW-1:0] sel);
    return (sel < NUM_REGS) ? regs_q[sel] : '0;
  endfunction

  // Writes to registers beyond the register file are dropped
  function automatic void write_reg(logic [RegSelW-1:0] sel, logic [DataW-1:0] val);
    if (sel < NUM_REGS) regs_q[sel] = val;
  endfunction

  function automatic logic [DataW-1:0] read_mem(logic [AddrW-1:0] addr);
    return (addr < MEM_WORDS) ? mem_q[addr] : '0;
  endfunction

  function automatic void write_mem(logic [AddrW-1:0] addr, logic [DataW-1:0] val);
    if (addr < MEM_WORDS) mem_q[addr] = val;
  endfunction

  // Execute one instruction against the mirrored state, return its result
  function automatic exec_result_t execute_instr(
    logic [KindW-1:0]   kind,
    logic [FormW-1:0]   form,
    logic [RegSelW-1:0] ra,
    logic [RegSelW-1:0] rb,
    logic [AddrW-1:0]   addr,
    logic [DataW-1:0]   imm,
    logic [TargetW-1:0] target
  );
    exec_result_t     res;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [LineW-1:0] nxt;
    logic [LineW-1:0] dest;
    res = '{default: '0};
    a = read_reg(ra);
    b = '0;
    nxt = line_q + 1'b1;
    // one-based target, wraps over the 256 program lines
    dest = target[LineW-1:0] - 1'b1;
    if (halt_q) begin
      nxt = line_q;
    end else begin
      case (kind)
        KIND_MOV: begin
          case (form)
            FORM_REG_REG:   write_reg(rb, a);
            FORM_REG_CONST: write_reg(ra, imm);
            FORM_REG_MEM:   write_mem(addr, a);
            FORM_MEM_REG:   write_reg(ra, read_mem(addr));
            FORM_MEM_CONST: write_mem(addr, imm);
            default: ;
          endcase
        end
        KIND_ADD, KIND_SUB: begin
          if (form == FORM_REG_REG || form == FORM_REG_CONST || form == FORM_REG_MEM) begin
            case (form)
              FORM_REG_REG:   b = read_reg(rb);
              FORM_REG_CONST: b = imm;
              default:        b = read_mem(addr);
            endcase
            write_reg(ra, (kind == KIND_ADD) ? a + b : a - b);
          end
        end
        KIND_PRN: begin
          case (form)
            FORM_REG: begin
              res.print_valid = 1'b1;
              res.print_value = a;
            end
            FORM_CONST: begin
              res.print_valid = 1'b1;
              res.print_value = imm;
            end
            FORM_MEM: begin
              res.print_valid    = 1'b1;
              res.print_value    = read_mem(addr);
              res.print_unsigned = 1'b1;
            end
            default: ;
          endcase
        end
        KIND_JMP: begin
          if (form != FORM_REG || a == '0) nxt = dest;
        end
        KIND_JPN: begin
          if (a == '0 || a[DataW-1]) nxt = dest;
        end
        KIND_HLT: begin
          halt_q = 1'b1;
          nxt = line_q;
        end
        default: ;
      endcase
    end
    line_q = nxt;
    res.next_line = nxt;
    res.halted = halt_q;
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] exp_val);
    $display("%0t: word %0d %s mismatch: got %h, want %h",
             $realtime, words_seen, what, got, exp_val);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    words_seen = 0;
  end

  // Predict on accepted instructions, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q = '0;
      halt_q = 1'b0;
      foreach (regs_q[i]) regs_q[i] = '0;
      foreach (mem_q[i]) mem_q[i] = '0;
      exec_results_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        exec_results_q.push_back(execute_instr(kind_i, operand_form_i, reg_a_i, reg_b_i,
                                               mem_address_i, immediate_i, target_line_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (exec_results_q.size() == 0) begin
          report_mismatch("unexpected word", {24'd0, next_line_i}, '0);
        end else begin
          want = exec_results_q.pop_front();
          if (next_line_i !== want.next_line)
            report_mismatch("next_line", {24'd0, next_line_i}, {24'd0, want.next_line});
          if (print_valid_i !== want.print_valid)
            report_mismatch("print_valid", {31'd0, print_valid_i}, {31'd0, want.print_valid});
          if (print_value_i !== want.print_value)
            report_mismatch("print_value", print_value_i, want.print_value);
          if (print_unsigned_i !== want.print_unsigned)
            report_mismatch("print_unsigned", {31'd0, print_unsigned_i},
                            {31'd0, want.print_unsigned});
          if (halted_i !== want.halted)
            report_mismatch("halted", {31'd0, halted_i}, {31'd0, want.halted});
        end
        words_seen++;
      end
    end
    pending_o = exec_results_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the toy register machine execute block
// Resets the block once, runs a directed instruction sequence over operand
// extremes, every kind and form and the wrap and out-of-range cases, then
// several hundred random instructions in bursts against a stalling receiver,
// and finally a halt followed by words that must be ignored. Checking is done
// by the checker instance next to the block.
// ----------------------------------------------------------------------------
module tb_top
  import trme_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_WORDS = 680;
  localparam int LONG_HOLD    = 90;

  // Codes outside the package: the no-operation kind and unused forms
  localparam logic [KindW-1:0] KIND_NOP       = 3'd7;
  localparam logic [FormW-1:0] FORM_UNUSED_LO = 3'd5;
  localparam logic [FormW-1:0] FORM_UNUSED_HI = 3'd7;

  // Register names; R1 is encoded as zero
  localparam logic [RegSelW-1:0] R1     = 3'd0;
  localparam logic [RegSelW-1:0] R2     = 3'd1;
  localparam logic [RegSelW-1:0] R3     = 3'd2;
  localparam logic [RegSelW-1:0] R4     = 3'd3;
  localparam logic [RegSelW-1:0] R5     = 3'd4;
  localparam logic [RegSelW-1:0] R_OUT5 = 3'd5;
  localparam logic [RegSelW-1:0] R_OUT6 = 3'd6;
  localparam logic [RegSelW-1:0] R_OUT7 = 3'd7;

  typedef struct {
    logic [KindW-1:0]   kind;
    logic [FormW-1:0]   form;
    logic [RegSelW-1:0] reg_a;
    logic [RegSelW-1:0] reg_b;
    logic [AddrW-1:0]   addr;
    logic [DataW-1:0]   imm;
    logic [TargetW-1:0] target;
  } instr_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [KindW-1:0]        kind_i;
  logic [FormW-1:0]        operand_form_i;
  logic [RegSelW-1:0]      reg_a_i;
  logic [RegSelW-1:0]      reg_b_i;
  logic [AddrW-1:0]        mem_address_i;
  logic signed [DataW-1:0] immediate_i;
  logic [TargetW-1:0]      target_line_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [LineW-1:0]        next_line_o;
  logic                    print_valid_o;
  logic signed [DataW-1:0] print_value_o;
  logic                    print_unsigned_o;
  logic                    halted_o;

  int fail_count;
  int pending;
  int cycle_count;
  int burst_left;

  toy_register_machine_execute_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .operand_form_i   (operand_form_i),
    .reg_a_i          (reg_a_i),
    .reg_b_i          (reg_b_i),
    .mem_address_i    (mem_address_i),
    .immediate_i      (immediate_i),
    .target_line_i    (target_line_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .next_line_o      (next_line_o),
    .print_valid_o    (print_valid_o),
    .print_value_o    (print_value_o),
    .print_unsigned_o (print_unsigned_o),
    .halted_o         (halted_o)
  );

  trme_exec_checker u_exec_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .operand_form_i   (operand_form_i),
    .reg_a_i          (reg_a_i),
    .reg_b_i          (reg_b_i),
    .mem_address_i    (mem_address_i),
    .immediate_i      (immediate_i),
    .target_line_i    (target_line_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .next_line_i      (next_line_o),
    .print_valid_i    (print_valid_o),
    .print_value_i    (print_value_o),
    .print_unsigned_i (print_unsigned_o),
    .halted_i         (halted_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words in flight", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic instr_t make_instr(
    logic [KindW-1:0]   kind,
    logic [FormW-1:0]   form,
    logic [RegSelW-1:0] ra,
    logic [RegSelW-1:0] rb,
    logic [AddrW-1:0]   addr,
    logic [DataW-1:0]   imm,
    logic [TargetW-1:0] target
  );
    instr_t w;
    w.kind   = kind;
    w.form   = form;
    w.reg_a  = ra;
    w.reg_b  = rb;
    w.addr   = addr;
    w.imm    = imm;
    w.target = target;
    return w;
  endfunction

  // Mix of full-range, small and extreme operand values
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 8)) - 32'd4;
      1: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return 32'd1;
          2:       return '1;
          3:       return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t w;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 26)      w.kind = KIND_MOV;
    else if (pick < 40) w.kind = KIND_ADD;
    else if (pick < 54) w.kind = KIND_SUB;
    else if (pick < 70) w.kind = KIND_PRN;
    else if (pick < 82) w.kind = KIND_JMP;
    else if (pick < 95) w.kind = KIND_JPN;
    else                w.kind = KIND_NOP;
    case (w.kind)
      KIND_MOV:                     w.form = FormW'($urandom_range(0, 4));
      KIND_ADD, KIND_SUB, KIND_PRN: w.form = FormW'($urandom_range(0, 2));
      default:                      w.form = FormW'($urandom_range(0, 7));
    endcase
    // sprinkle unused forms, keep the conditional jump common
    if ($urandom_range(0, 19) == 0) w.form = FormW'($urandom_range(0, 7));
    if (w.kind == KIND_JMP && $urandom_range(0, 1) == 0) w.form = FORM_REG;
    w.reg_a = ($urandom_range(0, 9) == 0) ? RegSelW'($urandom_range(5, 7))
                                          : RegSelW'($urandom_range(0, 4));
    w.reg_b = ($urandom_range(0, 9) == 0) ? RegSelW'($urandom_range(5, 7))
                                          : RegSelW'($urandom_range(0, 4));
    // a narrow address window makes reads hit earlier writes
    w.addr = ($urandom_range(0, 1) == 0) ? AddrW'($urandom_range(0, 7))
                                         : AddrW'($urandom_range(0, 63));
    w.imm = pick_value();
    w.target = ($urandom_range(0, 3) == 0) ? TargetW'($urandom_range(1, 256))
                                           : TargetW'($urandom_range(0, 511));
    return w;
  endfunction

  // Offer one word in bursts with random gaps, hold it until accepted
  task automatic send_word(instr_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    kind_i         <= w.kind;
    operand_form_i <= w.form;
    reg_a_i        <= w.reg_a;
    reg_b_i        <= w.reg_b;
    mem_address_i  <= w.addr;
    immediate_i    <= w.imm;
    target_line_i  <= w.target;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Receiver stall: segments of free flow, light, heavy and toggling stall,
  // with a long hold-off early on and now and then later
  initial begin : out_stall_gen
    int seg_no;
    int seg_len;
    int mode;
    seg_no = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      seg_no++;
      if (seg_no == 4 || $urandom_range(0, 29) == 0) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        seg_len = $urandom_range(10, 60);
        repeat (seg_len) begin
          @(posedge clk_i);
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 3) == 0);
            2:       out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ~out_stall_i;
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    instr_t directed_q [$];
    instr_t after_halt_q [$];
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    kind_i         <= KIND_MOV;
    operand_form_i <= FORM_REG_REG;
    reg_a_i        <= R1;
    reg_b_i        <= R1;
    mem_address_i  <= '0;
    immediate_i    <= '0;
    target_line_i  <= '0;
    burst_left = 0;

    // operand extremes and wrapping arithmetic
    directed_q.push_back(make_instr(KIND_MOV, FORM_REG_CONST, R1, R1, 6'd0, 32'h7FFF_FFFF, 9'd1));
    directed_q.push_back(make_instr(KIND_MOV, FORM_REG_CONST, R2, R1, 6'd0, 32'h8000_0000, 9'd1));
    directed_q.push_back(make_instr(KIND_ADD, FORM_REG_REG, R1, R2, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_ADD, FORM_REG_CONST, R1, R1, 6'd0, 32'd1, 9'd1));
    directed_q.push_back(make_instr(KIND_SUB, FORM_REG_CONST, R2, R1, 6'd0, 32'd1, 9'd1));
    // memory paths, unsigned print of a memory word
    directed_q.push_back(make_instr(KIND_MOV, FORM_MEM_CONST, R1, R1, 6'd63, '1, 9'd1));
    directed_q.push_back(make_instr(KIND_PRN, FORM_MEM, R1, R1, 6'd63, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_MOV, FORM_REG_MEM, R2, R1, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_MOV, FORM_MEM_REG, R5, R1, 6'd63, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_MOV, FORM_REG_REG, R5, R3, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_SUB, FORM_REG_MEM, R3, R1, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_PRN, FORM_REG, R3, R1, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_PRN, FORM_CONST, R1, R1, 6'd0, 32'h8000_0000, 9'd1));
    // unused forms and the no-operation kind
    directed_q.push_back(make_instr(KIND_ADD, FORM_MEM_REG, R1, R2, 6'd0, 32'd9, 9'd1));
    directed_q.push_back(make_instr(KIND_MOV, FORM_UNUSED_HI, R1, R2, 6'd0, 32'd9, 9'd1));
    directed_q.push_back(make_instr(KIND_PRN, FORM_UNUSED_LO, R2, R1, 6'd0, 32'd9, 9'd1));
    directed_q.push_back(make_instr(KIND_NOP, FORM_UNUSED_HI, R2, R1, 6'd0, 32'd9, 9'd3));
    // registers beyond the file read as zero, writes are dropped
    directed_q.push_back(make_instr(KIND_MOV, FORM_REG_CONST, R_OUT7, R1, 6'd0, 32'd5, 9'd1));
    directed_q.push_back(make_instr(KIND_ADD, FORM_REG_REG, R2, R_OUT5, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_PRN, FORM_REG, R_OUT6, R1, 6'd0, '0, 9'd1));
    // jumps: taken and not, line wrap in both directions
    directed_q.push_back(make_instr(KIND_JMP, FORM_REG, R1, R1, 6'd0, '0, 9'd256));
    directed_q.push_back(make_instr(KIND_SUB, FORM_REG_REG, R4, R3, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_JMP, FORM_REG, R3, R1, 6'd0, '0, 9'd9));
    directed_q.push_back(make_instr(KIND_JMP, FORM_CONST, R3, R1, 6'd0, '0, 9'd1));
    directed_q.push_back(make_instr(KIND_JMP, FORM_MEM, R3, R1, 6'd5, '0, 9'd0));
    directed_q.push_back(make_instr(KIND_JPN, FORM_REG, R2, R1, 6'd0, '0, 9'd5));
    directed_q.push_back(make_instr(KIND_JPN, FORM_REG, R1, R1, 6'd0, '0, 9'd511));
    directed_q.push_back(make_instr(KIND_JPN, FORM_CONST, R4, R1, 6'd0, '0, 9'd2));

    // halt, then words that must leave the state untouched
    after_halt_q.push_back(make_instr(KIND_HLT, FORM_REG, R1, R1, 6'd0, '0, 9'd1));
    after_halt_q.push_back(make_instr(KIND_PRN, FORM_CONST, R1, R1, 6'd0, 32'd77, 9'd1));
    after_halt_q.push_back(make_instr(KIND_MOV, FORM_REG_CONST, R1, R1, 6'd0, 32'd3, 9'd1));
    after_halt_q.push_back(make_instr(KIND_JMP, FORM_CONST, R1, R1, 6'd0, '0, 9'd40));
    after_halt_q.push_back(make_instr(KIND_PRN, FORM_REG, R1, R1, 6'd0, '0, 9'd1));

    // reset
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_word(directed_q[i]);
    repeat (RANDOM_WORDS) send_word(random_instr());
    foreach (after_halt_q[i]) send_word(after_halt_q[i]);
    in_valid_i <= 1'b0;

    // drain, then give stray words time to show up
    do @(negedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
